FILE: hdl/ppmd_pkg.sv
// Shared types, constants and helpers for the point position Morton/delta encoder.
// Used by ppmd_axis and the top level; depends on nothing.
`default_nettype none

package ppmd_pkg;

    localparam int unsigned NUM_AXES    = 3;
    localparam int unsigned AXIS_STAGES = 5;
    localparam int unsigned POS_W       = 32;
    localparam int unsigned INV_W       = 48;
    localparam int unsigned FRAC_BITS   = 47;
    localparam int unsigned GRID_W      = 10;
    localparam int unsigned QUANT_W     = 16;
    localparam int unsigned CODE_W      = NUM_AXES * GRID_W;
    localparam int unsigned PADDR_W     = 6;
    localparam int unsigned PDATA_W     = 64;

    localparam logic [GRID_W-1:0]  GRID_MAX     = 10'h3FF;
    localparam logic [QUANT_W-1:0] QUANT_MAX    = 16'hFFFF;
    localparam logic [QUANT_W-1:0] QUANT_OFFSET = 16'h8000;
    localparam logic [INV_W-1:0]   INV_RESET    = 48'h0000_8000_0000;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_INV_X = 3'd3,
        REG_INV_Y = 3'd4,
        REG_INV_Z = 3'd5
    } t_reg_idx;

    // per-stage load strobes of the axis pipeline
    typedef struct packed {
        logic [AXIS_STAGES-1:0] load;
    } t_pipe_ctrl;

    // interleave three grid values: x in bit 0, y in bit 1, z in bit 2 of each group
    function automatic logic [CODE_W-1:0] morton3(
        input logic [GRID_W-1:0] gx,
        input logic [GRID_W-1:0] gy,
        input logic [GRID_W-1:0] gz
    );
        logic [CODE_W-1:0] code;
        code = '0;
        for (int i = 0; i < GRID_W; i++) begin
            code[NUM_AXES*i]     = gx[i];
            code[NUM_AXES*i + 1] = gy[i];
            code[NUM_AXES*i + 2] = gz[i];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/point_position_morton_delta_encoder_core.sv
// Top level of the point position encoder: handshake, APB registers, Morton code
// and delta predictors. Uses ppmd_pkg and three ppmd_axis instances.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_pos_x/y/z, i_first_of_set
//  result    out        o_valid / i_ready     o_zorder_code, o_delta_x/y/z
//  config    in/out     psel, penable, pready paddr, pwrite, pwdata, prdata
//
// One item per cycle while results are taken, through six register stages (input,
// offset, partial products, sum, scale, output). Synchronous active-low reset clears
// valid bits and predictors, zeroes the minimums and sets reciprocals to INV_RESET.
// A stalled result holds the output register; upstream stages keep filling
// bubbles, so o_ready drops only when all stages hold items.
`default_nettype none

module point_position_morton_delta_encoder_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [ppmd_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic signed [ppmd_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic signed [ppmd_pkg::POS_W-1:0]    i_pos_z,
    input  wire logic                                 i_first_of_set,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic             [ppmd_pkg::CODE_W-1:0]   o_zorder_code,
    output logic signed      [ppmd_pkg::QUANT_W-1:0]  o_delta_x,
    output logic signed      [ppmd_pkg::QUANT_W-1:0]  o_delta_y,
    output logic signed      [ppmd_pkg::QUANT_W-1:0]  o_delta_z,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [ppmd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [ppmd_pkg::PDATA_W-1:0]  pwdata,
    output logic             [ppmd_pkg::PDATA_W-1:0]  prdata,
    output logic                                      pready
);
    import ppmd_pkg::*;

    logic signed [POS_W-1:0]   r_min [NUM_AXES];
    logic        [INV_W-1:0]   r_inv [NUM_AXES];
    logic        [QUANT_W-1:0] r_last [NUM_AXES];
    logic        [AXIS_STAGES-1:0] r_vld;
    logic        [AXIS_STAGES-1:0] r_first;
    logic                      r_out_valid;
    logic        [CODE_W-1:0]  r_code;
    logic        [QUANT_W-1:0] r_delta [NUM_AXES];

    logic        [AXIS_STAGES:0] can_load;
    t_pipe_ctrl                ctrl;
    logic signed [POS_W-1:0]   pos [NUM_AXES];
    logic        [GRID_W-1:0]  grid [NUM_AXES];
    logic        [QUANT_W-1:0] quant [NUM_AXES];
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;
    logic                      upd;

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    // a stage takes a new item when empty or when its item moves on
    always_comb begin
        can_load[AXIS_STAGES] = !r_out_valid || i_ready;
        for (int k = AXIS_STAGES - 1; k >= 0; k--) begin
            can_load[k] = !r_vld[k] || can_load[k+1];
        end
        ctrl.load = can_load[AXIS_STAGES-1:0];
    end

    assign o_ready = can_load[0];
    assign upd     = can_load[AXIS_STAGES] && r_vld[AXIS_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < AXIS_STAGES; k++) begin
                if (can_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (can_load[AXIS_STAGES]) begin
                r_out_valid <= r_vld[AXIS_STAGES-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load[0]) begin
            r_first[0] <= i_first_of_set;
        end
        for (int k = 1; k < AXIS_STAGES; k++) begin
            if (can_load[k]) begin
                r_first[k] <= r_first[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_AXES; g++) begin : gen_axis
            ppmd_axis u_axis (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_pos   (pos[g]),
                .i_min   (r_min[g]),
                .i_inv   (r_inv[g]),
                .o_grid  (grid[g]),
                .o_quant (quant[g])
            );
        end
    endgenerate

    // predictors: a set restart compares against zero, then keep this item's value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_last[c] <= '0;
            end
        end else if (upd) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_last[c] <= quant[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_code <= morton3(grid[0], grid[1], grid[2]);
            for (int c = 0; c < NUM_AXES; c++) begin
                r_delta[c] <= quant[c] - (r_first[AXIS_STAGES-1] ? '0 : r_last[c]);
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_zorder_code = r_code;
    assign o_delta_x     = r_delta[0];
    assign o_delta_y     = r_delta[1];
    assign o_delta_z     = r_delta[2];

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_min[c] <= '0;
                r_inv[c] <= INV_RESET;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MIN_X: r_min[0] <= pwdata[POS_W-1:0];
                REG_MIN_Y: r_min[1] <= pwdata[POS_W-1:0];
                REG_MIN_Z: r_min[2] <= pwdata[POS_W-1:0];
                REG_INV_X: r_inv[0] <= pwdata[INV_W-1:0];
                REG_INV_Y: r_inv[1] <= pwdata[INV_W-1:0];
                REG_INV_Z: r_inv[2] <= pwdata[INV_W-1:0];
                default: begin
                    // drop writes to unused addresses
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MIN_X: prdata = {{(PDATA_W-POS_W){1'b0}}, r_min[0]};
            REG_MIN_Y: prdata = {{(PDATA_W-POS_W){1'b0}}, r_min[1]};
            REG_MIN_Z: prdata = {{(PDATA_W-POS_W){1'b0}}, r_min[2]};
            REG_INV_X: prdata = {{(PDATA_W-INV_W){1'b0}}, r_inv[0]};
            REG_INV_Y: prdata = {{(PDATA_W-INV_W){1'b0}}, r_inv[1]};
            REG_INV_Z: prdata = {{(PDATA_W-INV_W){1'b0}}, r_inv[2]};
            default:   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/ppmd_axis.sv
// One axis of the encoder: offset, reciprocal scaling, grid and quantized value.
// Five register stages under load strobes from the top level; uses ppmd_pkg.
`default_nettype none

module ppmd_axis (
    input  wire logic                              i_clk,
    input  wire ppmd_pkg::t_pipe_ctrl              i_ctrl,
    input  wire logic signed [ppmd_pkg::POS_W-1:0] i_pos,
    input  wire logic signed [ppmd_pkg::POS_W-1:0] i_min,
    input  wire logic        [ppmd_pkg::INV_W-1:0] i_inv,
    output logic             [ppmd_pkg::GRID_W-1:0]  o_grid,
    output logic             [ppmd_pkg::QUANT_W-1:0] o_quant
);
    import ppmd_pkg::*;

    localparam int unsigned DIFF_W = POS_W + 1;
    localparam int unsigned INV_LO = 32;
    localparam int unsigned PLO_W  = POS_W + INV_LO;
    localparam int unsigned PHI_W  = POS_W + INV_W - INV_LO;
    localparam int unsigned PROD_W = POS_W + INV_W;
    localparam int unsigned GP_W   = FRAC_BITS + GRID_W;
    localparam int unsigned QP_W   = FRAC_BITS + QUANT_W;

    logic signed [POS_W-1:0]   r_pos;
    logic        [POS_W-1:0]   r_ud;
    logic        [PLO_W-1:0]   r_pp_lo;
    logic        [PHI_W-1:0]   r_pp_hi;
    logic                      r_over;
    logic        [FRAC_BITS-1:0] r_frac;
    logic        [GRID_W-1:0]  r_grid;
    logic        [QUANT_W-1:0] r_quant;

    logic signed [DIFF_W-1:0]  diff;
    logic        [POS_W-1:0]   n_ud;
    logic        [PROD_W-1:0]  prod;
    logic        [GP_W-1:0]    grid_prod;
    logic        [QP_W-1:0]    quant_prod;
    logic        [GRID_W-1:0]  n_grid;
    logic        [QUANT_W-1:0] n_quant;

    // points at or below the minimum scale to zero
    always_comb begin
        diff = {r_pos[POS_W-1], r_pos} - {i_min[POS_W-1], i_min};
        n_ud = (!diff[DIFF_W-1] && (|diff[POS_W-1:0])) ? diff[POS_W-1:0] : '0;
    end

    assign prod = {{(PROD_W-PLO_W){1'b0}}, r_pp_lo} + {r_pp_hi, {INV_LO{1'b0}}};

    // norm * k as (frac << log2(k+1)) - frac, taken above the fraction point
    always_comb begin
        grid_prod  = {r_frac, {GRID_W{1'b0}}}  - {{GRID_W{1'b0}}, r_frac};
        quant_prod = {r_frac, {QUANT_W{1'b0}}} - {{QUANT_W{1'b0}}, r_frac};
        n_grid     = r_over ? GRID_MAX : grid_prod[GP_W-1:FRAC_BITS];
        n_quant    = (r_over ? QUANT_MAX : quant_prod[QP_W-1:FRAC_BITS]) ^ QUANT_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[0]) begin
            r_pos <= i_pos;
        end
        if (i_ctrl.load[1]) begin
            r_ud <= n_ud;
        end
        if (i_ctrl.load[2]) begin
            r_pp_lo <= PLO_W'(r_ud) * PLO_W'(i_inv[INV_LO-1:0]);
            r_pp_hi <= PHI_W'(r_ud) * PHI_W'(i_inv[INV_W-1:INV_LO]);
        end
        if (i_ctrl.load[3]) begin
            r_over <= |prod[PROD_W-1:FRAC_BITS];
            r_frac <= prod[FRAC_BITS-1:0];
        end
        if (i_ctrl.load[4]) begin
            r_grid  <= n_grid;
            r_quant <= n_quant;
        end
    end

    assign o_grid  = r_grid;
    assign o_quant = r_quant;

endmodule

`default_nettype wire

FILE: hdl/ppmd_checker.sv
// Port-level checks for the point position encoder, bound to the top level.
// Uses ppmd_pkg for widths; sees top-level ports only.
`default_nettype none

module ppmd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic [ppmd_pkg::CODE_W-1:0]         o_zorder_code,
    input wire logic [ppmd_pkg::QUANT_W-1:0]        o_delta_x,
    input wire logic [ppmd_pkg::QUANT_W-1:0]        o_delta_y,
    input wire logic [ppmd_pkg::QUANT_W-1:0]        o_delta_z
);
    import ppmd_pkg::*;

    localparam int unsigned DEPTH = AXIS_STAGES + 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_inflight;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_zorder_code) && $stable(o_delta_x)
                                && $stable(o_delta_y) && $stable(o_delta_z))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != '0)
        else $error("result shown with no item in flight");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind point_position_morton_delta_encoder_core ppmd_checker u_ppmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_zorder_code (o_zorder_code),
    .o_delta_x     (o_delta_x),
    .o_delta_y     (o_delta_y),
    .o_delta_z     (o_delta_z)
);

`default_nettype wire

FILE: bench/point_code_checker.sv
// Checker for the point position encoder: tracks the box registers from the APB bus,
// predicts the Morton code and axis deltas of every accepted point and compares results.
// Depends on ppmd_pkg for widths, register indexes and scale constants.
`timescale 1ns / 1ps

module point_code_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pt_valid,
    input  logic                                i_pt_ready,
    input  logic signed [ppmd_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [ppmd_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [ppmd_pkg::POS_W-1:0]   i_pos_z,
    input  logic                                i_first_of_set,
    input  logic                                i_code_valid,
    input  logic                                i_code_ready,
    input  logic        [ppmd_pkg::CODE_W-1:0]  i_zorder_code,
    input  logic signed [ppmd_pkg::QUANT_W-1:0] i_delta_x,
    input  logic signed [ppmd_pkg::QUANT_W-1:0] i_delta_y,
    input  logic signed [ppmd_pkg::QUANT_W-1:0] i_delta_z,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic        [ppmd_pkg::PADDR_W-1:0] i_paddr,
    input  logic        [ppmd_pkg::PDATA_W-1:0] i_pwdata,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import ppmd_pkg::*;

    typedef struct packed {
        logic        [CODE_W-1:0]  code;
        logic signed [QUANT_W-1:0] dx;
        logic signed [QUANT_W-1:0] dy;
        logic signed [QUANT_W-1:0] dz;
    } t_point_code;

    logic [NUM_AXES-1:0][POS_W-1:0]   box_min;
    logic [NUM_AXES-1:0][INV_W-1:0]   box_recip;
    logic [NUM_AXES-1:0][QUANT_W-1:0] prev_quant;
    t_point_code                      expected_codes[$];
    int                               mismatches = 0;
    int                               outstanding = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = outstanding;

    // floor(offset * recip * full_scale / 2^47), capped at full_scale
    function automatic logic [QUANT_W-1:0] scale_offset(
        input logic [POS_W:0]     offset,
        input logic [INV_W-1:0]   recip,
        input logic [QUANT_W-1:0] full_scale
    );
        logic [127:0] acc;
        acc = {95'd0, offset} * {80'd0, recip};
        acc = (acc * {112'd0, full_scale}) >> FRAC_BITS;
        if (acc > {112'd0, full_scale})
            return full_scale;
        return acc[QUANT_W-1:0];
    endfunction

    // advances the delta predictors as a side effect
    function automatic t_point_code encode_point(
        input logic [NUM_AXES-1:0][POS_W-1:0] coords,
        input logic                           first
    );
        t_point_code             res;
        logic signed [POS_W:0]   offset;
        logic [QUANT_W-1:0]      grid;
        logic [QUANT_W-1:0]      quant;
        logic [QUANT_W-1:0]      delta[NUM_AXES];
        res = '0;
        if (first)
            prev_quant = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            offset = $signed({coords[a][POS_W-1], coords[a]})
                   - $signed({box_min[a][POS_W-1], box_min[a]});
            grid  = '0;
            quant = '0;
            if (offset > 0) begin
                grid  = scale_offset(offset, box_recip[a], {6'd0, GRID_MAX});
                quant = scale_offset(offset, box_recip[a], QUANT_MAX);
            end
            quant         = quant - QUANT_OFFSET;
            delta[a]      = quant - prev_quant[a];
            prev_quant[a] = quant;
            for (int b = 0; b < GRID_W; b++)
                res.code[NUM_AXES*b + a] = grid[b];
        end
        res.dx = delta[0];
        res.dy = delta[1];
        res.dz = delta[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_point_code want;
        t_point_code got;
        if (!i_rst_n) begin
            box_min    = '0;
            box_recip  = {NUM_AXES{INV_RESET}};
            prev_quant = '0;
            expected_codes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:3])
                    REG_MIN_X: box_min[0]   = i_pwdata[POS_W-1:0];
                    REG_MIN_Y: box_min[1]   = i_pwdata[POS_W-1:0];
                    REG_MIN_Z: box_min[2]   = i_pwdata[POS_W-1:0];
                    REG_INV_X: box_recip[0] = i_pwdata[INV_W-1:0];
                    REG_INV_Y: box_recip[1] = i_pwdata[INV_W-1:0];
                    REG_INV_Z: box_recip[2] = i_pwdata[INV_W-1:0];
                    default: ;
                endcase
            end
            if (i_code_valid && i_code_ready) begin
                got = {i_zorder_code, i_delta_x, i_delta_y, i_delta_z};
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result code=%h dx=%0d dy=%0d dz=%0d",
                                 $realtime, got.code, $signed(got.dx), $signed(got.dy),
                                 $signed(got.dz));
                end else begin
                    want = expected_codes.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: mismatch expected code=%h dx=%0d dy=%0d dz=%0d",
                                   $realtime, want.code, $signed(want.dx),
                                   $signed(want.dy), $signed(want.dz));
                            $display(" got code=%h dx=%0d dy=%0d dz=%0d",
                                     got.code, $signed(got.dx), $signed(got.dy),
                                     $signed(got.dz));
                        end
                    end
                end
            end
            if (i_pt_valid && i_pt_ready)
                expected_codes.insert(expected_codes.size(),
                                      encode_point({i_pos_z, i_pos_y, i_pos_x},
                                                   i_first_of_set));
        end
        outstanding = expected_codes.size();
    end

endmodule

FILE: bench/point_position_morton_delta_encoder_core_tb.sv
// Testbench top for the point position encoder: clock, reset, box register writes,
// directed and random point stimulus, and the verdict.
// Depends on ppmd_pkg, the encoder core and point_code_checker.
`timescale 1ns / 1ps

module point_position_morton_delta_encoder_core_tb;
    import ppmd_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASES       = 10;
    localparam int          PHASE_POINTS = 65;
    localparam logic [2:0]  REG_UNUSED   = 3'd6;
    localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [47:0] RECIP_MAX    = 48'hFFFF_FFFF_FFFF;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_valid        = 1'b0;
    logic                      o_ready;
    logic signed [POS_W-1:0]   i_pos_x        = '0;
    logic signed [POS_W-1:0]   i_pos_y        = '0;
    logic signed [POS_W-1:0]   i_pos_z        = '0;
    logic                      i_first_of_set = 1'b0;
    logic                      o_valid;
    logic                      i_ready        = 1'b0;
    logic        [CODE_W-1:0]  o_zorder_code;
    logic signed [QUANT_W-1:0] o_delta_x;
    logic signed [QUANT_W-1:0] o_delta_y;
    logic signed [QUANT_W-1:0] o_delta_z;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic        [PADDR_W-1:0] paddr          = '0;
    logic        [PDATA_W-1:0] pwdata         = '0;
    logic        [PDATA_W-1:0] prdata;
    logic                      pready;

    int                        mismatches;
    int                        pending;
    int                        cycles         = 0;
    logic                      calm           = 1'b0;
    logic signed [POS_W-1:0]   box_min[NUM_AXES];
    logic        [INV_W-1:0]   box_recip[NUM_AXES];

    point_position_morton_delta_encoder_core u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_first_of_set, .o_valid, .i_ready, .o_zorder_code, .o_delta_x, .o_delta_y,
        .o_delta_z, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    point_code_checker u_checker (
        .i_clk, .i_rst_n,
        .i_pt_valid     (i_valid),
        .i_pt_ready     (o_ready),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_first_of_set,
        .i_code_valid   (o_valid),
        .i_code_ready   (i_ready),
        .i_zorder_code  (o_zorder_code),
        .i_delta_x      (o_delta_x),
        .i_delta_y      (o_delta_y),
        .i_delta_z      (o_delta_z),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 6);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] clamp_coord(input longint value);
        if (value > longint'($signed(COORD_MAX)))
            return COORD_MAX;
        if (value < longint'($signed(COORD_MIN)))
            return COORD_MIN;
        return value[31:0];
    endfunction

    // mostly points inside the box, some just past its faces, some anywhere
    function automatic logic [31:0] pick_coord(input int axis);
        longint unsigned span;
        longint          offs;
        longint          low;
        int              pick;
        low  = longint'(box_min[axis]);
        span = (box_recip[axis] == 0) ? (64'd1 << 33) : (64'd1 << 47) / box_recip[axis];
        if (span > (64'd1 << 33))
            span = 64'd1 << 33;
        pick = $urandom_range(99);
        if (pick < 70) begin
            offs = {$urandom, $urandom} % (span + span / 16 + 1);
            return clamp_coord(low + offs);
        end
        if (pick < 85)
            return $urandom;
        case ($urandom_range(7))
            0: return box_min[axis];
            1: return box_min[axis] - 1;
            2: return box_min[axis] + 1;
            3: return clamp_coord(low + longint'(span));
            4: return clamp_coord(low + longint'(span) - 1);
            5: return COORD_MIN;
            6: return COORD_MAX;
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] pick_min();
        case ($urandom_range(5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] pick_recip();
        int          shift;
        logic [47:0] base;
        case ($urandom_range(7))
            0: return '0;
            1: return RECIP_MAX;
            2: return 48'({$urandom, $urandom});
            3: return INV_RESET;
            default: begin
                shift = $urandom_range(14, 39);
                base  = 48'd1 << shift;
                return base | (48'({$urandom, $urandom}) & (base - 48'd1));
            end
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the stream until every result is back, then load a new box
    task automatic set_box(input logic [2:0][31:0] mins, input logic [2:0][47:0] recips);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (AXIS_STAGES + 3) @(negedge i_clk);
        // junk in the unused upper data bits must be dropped
        write_reg(REG_MIN_X, {$urandom, mins[0]});
        write_reg(REG_MIN_Y, {$urandom, mins[1]});
        write_reg(REG_MIN_Z, {$urandom, mins[2]});
        write_reg(REG_INV_X, {16'($urandom), recips[0]});
        write_reg(REG_INV_Y, {16'($urandom), recips[1]});
        write_reg(REG_INV_Z, {16'($urandom), recips[2]});
        for (int a = 0; a < NUM_AXES; a++) begin
            box_min[a]   = mins[a];
            box_recip[a] = recips[a];
        end
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic first);
        while (!calm && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pos_x        <= x;
        i_pos_y        <= y;
        i_pos_z        <= z;
        i_first_of_set <= first;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        logic [2:0][31:0] mins;
        logic [2:0][47:0] recips;
        for (int a = 0; a < NUM_AXES; a++) begin
            box_min[a]   = '0;
            box_recip[a] = INV_RESET;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset box: unit extent from the origin
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);
        send_point(32'h0000_8000, 32'h0000_4000, 32'h0000_C000, 1'b0);
        send_point(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_point(32'h0000_5555, 32'h0000_AAAA, 32'h0000_3333, 1'b1);

        // box from -8.0 spanning 16.0 on every axis
        mins   = {3{32'hFFF8_0000}};
        recips = {3{48'h0000_0800_0000}};
        set_box(mins, recips);
        write_reg(REG_UNUSED, {2{32'hFFFF_FFFF}});
        send_point(32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000, 1'b1);
        send_point(32'hFFF7_FFFF, 32'hFFF8_0001, 32'hFFF7_FFFF, 1'b0);
        send_point(32'h0007_FFFF, 32'h0008_0000, 32'h0008_0001, 1'b0);
        send_point(32'hFFF8_0000, 32'h0008_0000, 32'hFFF8_0000, 1'b0);
        send_point(32'h0008_0000, 32'hFFF8_0000, 32'h0008_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0004_0000, 32'hFFFC_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0004_0000, 32'hFFFC_0000, 1'b1);
        send_point(32'hFFF8_0040, 32'h0007_FFC0, 32'h0000_0010, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 32'h0000_0000, 1'b0);
        send_point(32'h1234_5678, 32'hFFF9_2345, 32'h0003_3333, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    mins   = {3{COORD_MIN}};
                    recips = {3{RECIP_MAX}};
                end
                2: begin
                    mins   = {32'h0000_0000, COORD_MAX, COORD_MIN};
                    recips = {48'd1, RECIP_MAX, 48'd0};
                end
                default: begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        mins[a]   = pick_min();
                        recips[a] = pick_recip();
                    end
                end
            endcase
            set_box(mins, recips);
            calm = (phase == 4);
            for (int n = 0; n < PHASE_POINTS; n++)
                send_point(pick_coord(0), pick_coord(1), pick_coord(2),
                           $urandom_range(15) == 0);
        end

        i_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (AXIS_STAGES + 5) @(negedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
